// ----- design/mpsg_pkg.sv -----
// Package for the motor PWM safety gate: field widths, opcode and phase codes,
// register indexes, the status snapshot type and the percent saturation helper.
// No dependencies.
package mpsg_pkg;

  // Default duty resolution and percent arithmetic.
  localparam int unsigned DUTY_BITS_DEF = 10;
  localparam int unsigned PCT_W         = 7;
  localparam int unsigned PCT_IN_W      = 8;
  localparam int unsigned OPC_W         = 3;
  localparam int unsigned PHASE_W       = 2;
  localparam longint unsigned PctFull   = 100;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Fractional bits of the fixed-point reciprocal used for the duty scaling.
  localparam int unsigned DUTY_SHIFT = 14;

  // Event opcodes.
  localparam logic [OPC_W-1:0] OP_BOOT    = 3'd0;
  localparam logic [OPC_W-1:0] OP_CAL     = 3'd1;
  localparam logic [OPC_W-1:0] OP_SPEED   = 3'd2;
  localparam logic [OPC_W-1:0] OP_OVR     = 3'd3;
  localparam logic [OPC_W-1:0] OP_RELEASE = 3'd4;

  // Phases.
  localparam logic [PHASE_W-1:0] PH_BOOT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CAL  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RUN  = 2'd2;

  // Configuration register map.
  localparam int unsigned ADDR_W  = 3;
  localparam logic        REG_MIN = 1'b0;
  localparam logic        REG_MAX = 1'b1;

  // Gate state, also reported with every result.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PCT_W-1:0]   speed;
    logic [PCT_W-1:0]   ovr_value;
    logic               ovr_on;
    logic               cal_done;
  } status_t;

  // Clamp a configured percent to full scale.
  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
    return (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

endpackage

// ----- design/mpsg_gate.sv -----
// Gate state and event decision for the motor PWM safety gate, with the duty
// scaling of the resulting speed. Depends on mpsg_pkg.
module mpsg_gate #(
  parameter int unsigned DUTY_BITS = mpsg_pkg::DUTY_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [mpsg_pkg::OPC_W-1:0]        opcode_i,
  input  logic [mpsg_pkg::PCT_IN_W-1:0]     percent_i,
  input  logic                              cal_flag_i,
  input  logic [mpsg_pkg::PCT_W-1:0]        min_speed_i,
  input  logic [mpsg_pkg::PCT_W-1:0]        max_speed_i,
  output logic                              accepted_o,
  output logic [DUTY_BITS-1:0]              duty_o,
  output mpsg_pkg::status_t                 status_o
);

  // Duty = floor(speed * (2^DUTY_BITS - 1) / 100) as speed * RECIP >> DUTY_SHIFT.
  // Exact for every speed below 128 since the rounding error stays under 2^-14.
  localparam longint unsigned DutyFull = (64'd1 << DUTY_BITS) - 64'd1;
  localparam longint unsigned Recip    =
    (DutyFull * (64'd1 << mpsg_pkg::DUTY_SHIFT) + mpsg_pkg::PctFull - 64'd1) /
    mpsg_pkg::PctFull;
  localparam int unsigned RECIP_W = $clog2(Recip + 64'd1);
  localparam int unsigned PROD_W  = mpsg_pkg::PCT_W + RECIP_W;

  mpsg_pkg::status_t           st_q, st_d;
  logic [mpsg_pkg::PCT_W-1:0]  lo, hi;
  logic                        pct_ok;
  logic                        acc;
  logic [PROD_W-1:0]           prod;

  assign lo     = mpsg_pkg::sat_pct(min_speed_i);
  assign hi     = mpsg_pkg::sat_pct(max_speed_i);
  assign pct_ok = (percent_i <= {1'b0, hi});

  // Check the event against phase and flags and form the next state.
  always_comb begin
    st_d = st_q;
    acc  = 1'b0;
    unique case (opcode_i)
      mpsg_pkg::OP_BOOT: begin
        if (st_q.phase == mpsg_pkg::PH_BOOT) begin
          st_d.speed = lo;
          st_d.phase = mpsg_pkg::PH_CAL;
          acc        = 1'b1;
        end
      end
      mpsg_pkg::OP_CAL: begin
        if (!cal_flag_i) begin
          if (st_q.phase != mpsg_pkg::PH_BOOT) begin
            st_d.speed     = lo;
            st_d.ovr_on    = 1'b0;
            st_d.ovr_value = lo;
            st_d.cal_done  = 1'b0;
            st_d.phase     = mpsg_pkg::PH_CAL;
            acc            = 1'b1;
          end
        end else if (st_q.phase == mpsg_pkg::PH_CAL && !st_q.cal_done) begin
          st_d.ovr_on    = 1'b0;
          st_d.ovr_value = lo;
          st_d.speed     = lo;
          st_d.cal_done  = 1'b1;
          st_d.phase     = mpsg_pkg::PH_RUN;
          acc            = 1'b1;
        end
      end
      mpsg_pkg::OP_SPEED: begin
        if (pct_ok && st_q.phase == mpsg_pkg::PH_RUN && st_q.cal_done && !st_q.ovr_on) begin
          st_d.speed = percent_i[mpsg_pkg::PCT_W-1:0];
          acc        = 1'b1;
        end
      end
      mpsg_pkg::OP_OVR: begin
        if (pct_ok && st_q.phase == mpsg_pkg::PH_CAL && !st_q.cal_done) begin
          st_d.ovr_value = percent_i[mpsg_pkg::PCT_W-1:0];
          st_d.speed     = percent_i[mpsg_pkg::PCT_W-1:0];
          st_d.ovr_on    = 1'b1;
          acc            = 1'b1;
        end
      end
      mpsg_pkg::OP_RELEASE: begin
        st_d.ovr_on = 1'b0;
        acc         = 1'b1;
      end
      default: begin
        // Unused opcodes leave the state alone and are not accepted.
      end
    endcase
  end

  // Gate state registers, updated once per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  // Duty count for the speed after this event.
  assign prod       = PROD_W'(st_d.speed) * PROD_W'(Recip);
  assign duty_o     = prod[mpsg_pkg::DUTY_SHIFT +: DUTY_BITS];
  assign accepted_o = acc;
  assign status_o   = st_d;

endmodule

// ----- design/motor_pwm_safety_gate_unit.sv -----
// Top level of the motor PWM safety gate: APB configuration registers, input
// register, result register and stream handshakes. Depends on mpsg_pkg, mpsg_gate.
//
// One event enters per clock while s_axis_tready_o is high, and one result leaves per
// event. An event taken from the input stream is held in the input register, is decided
// against the gate state and scaled to a duty count by one constant multiplication,
// and lands in the result register, from which its result is offered on the result
// stream. Both registers move on together, so a sustained rate of one event per cycle
// holds whenever the output side takes results every cycle; a stalled output fills the
// two registers and then holds s_axis_tready_o low. min_speed (byte address 0) and
// max_speed (byte address 4) must be written by the user over APB only while no event
// is in flight; the block does not enforce this.
module motor_pwm_safety_gate_unit #(
  parameter int unsigned DUTY_BITS = mpsg_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpsg_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Event stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] percent, [8] cal_flag, [15:9] zero
  input  logic [15:0]                     s_axis_tdata_i,
  // [2:0] opcode
  input  logic [mpsg_pkg::OPC_W-1:0]      s_axis_tuser_i,
  // Result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] accepted, duty, phase (2), speed_now (7), override_value (7),
  // override_on, cal_complete, then zero fill
  output logic [((DUTY_BITS + 19 + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int unsigned OUT_W = ((DUTY_BITS + 19 + 7) / 8) * 8;

  logic [mpsg_pkg::PCT_W-1:0]    min_speed_q, max_speed_q;
  logic                          cfg_wr;
  logic                          in_valid_q;
  logic [mpsg_pkg::OPC_W-1:0]    opcode_q;
  logic [mpsg_pkg::PCT_IN_W-1:0] percent_q;
  logic                          cal_flag_q;
  logic                          in_fire, advance;
  logic                          out_valid_q;
  logic                          accepted_d, accepted_q;
  logic [DUTY_BITS-1:0]          duty_d, duty_q;
  mpsg_pkg::status_t             status_d, status_q;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q <= '0;
      max_speed_q <= mpsg_pkg::PCT_FULL;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mpsg_pkg::REG_MIN: min_speed_q <= pwdata[mpsg_pkg::PCT_W-1:0];
        mpsg_pkg::REG_MAX: max_speed_q <= pwdata[mpsg_pkg::PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == mpsg_pkg::REG_MAX) ? 32'(max_speed_q) : 32'(min_speed_q);

  // Pipeline flow: the input register moves into the result register whenever
  // the result register is empty or being emptied this cycle.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign in_fire         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      opcode_q   <= s_axis_tuser_i;
      percent_q  <= s_axis_tdata_i[mpsg_pkg::PCT_IN_W-1:0];
      cal_flag_q <= s_axis_tdata_i[mpsg_pkg::PCT_IN_W];
    end
  end

  mpsg_gate #(
    .DUTY_BITS (DUTY_BITS)
  ) u_gate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .opcode_i    (opcode_q),
    .percent_i   (percent_q),
    .cal_flag_i  (cal_flag_q),
    .min_speed_i (min_speed_q),
    .max_speed_i (max_speed_q),
    .accepted_o  (accepted_d),
    .duty_o      (duty_d),
    .status_o    (status_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      accepted_q <= accepted_d;
      duty_q     <= duty_d;
      status_q   <= status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({status_q.cal_done, status_q.ovr_on, status_q.ovr_value,
                                   status_q.speed, status_q.phase, duty_q, accepted_q});

endmodule
